[rtl/bb3_pkg.sv]
package bb3_pkg;

   // Fixed widths of the stream and register fields.
   localparam int CHAN_W = 16;
   localparam int DATA_W = 3 * CHAN_W;
   localparam int CSR_W  = 11;

   // Frame width after reset.
   localparam logic [CSR_W-1:0] FRAME_WIDTH_RESET = 11'd512;

   // Kind of an incoming word, carried on tuser.
   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_DRAIN = 1'b1
   } mode_type;

   // Where the output pixel sits relative to the frame border.
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } edge_type;

endpackage

[rtl/box_blur_3x3_edge_clipped_core.sv]
// 3x3 box blur over a square RGB frame with border-clipped averaging.
// Input channel req_*: one word per pixel in raster order (tuser = 0), then
// width+1 drain words (tuser = 1) that flush the last outputs of the frame.
// Pixels that arrive during the flush, and drains that arrive before the
// frame is complete, are taken and dropped without a result.
// Result channel rsp_*: smoothed pixels in raster order; the output for a
// pixel is released by the input word that comes width+1 words after it,
// and tlast marks the final pixel of the frame.
// Results pass stages A to E and the output register. Throughput: one word
// per cycle while the output is not stalled. The line store is read at the
// incoming word's column and written back as it leaves stage A, one read
// and one write per cycle; a write to the entry being read is forwarded.
// csr_we loads the frame width (0 acts as 1, values above MAX_WIDTH as
// MAX_WIDTH) and restarts the frame; write it only while the block is idle.
// Reset sets the width to 512 and starts a new frame; the line store is
// not cleared, as no output depends on an entry the frame has not written.
// A stall on rsp_tready freezes the whole pipeline and drops req_tready.
module box_blur_3x3_edge_clipped_core
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH    = 1024,
   parameter int CHANNEL_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // red_in, green_in, blue_in
   input  logic [0:0]        req_tuser,   // mode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // red_out, green_out, blue_out
   output logic              rsp_tlast,   // frame_last
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int CB = CHANNEL_BITS;
   localparam int SW = CB + 4;
   localparam int CSW = CB + 2;
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_WIDTH + 2);
   localparam int CW = (WW > CSR_W) ? WW : CSR_W;
   localparam int EW = 6 * CB;

   // Reciprocals for the divide by the neighbor count.
   localparam logic [SW-1:0] RECIP_1 = SW'((64'd1 << SW) - 64'd1);
   localparam logic [SW-1:0] RECIP_2 = SW'((64'd1 << SW) / 2);
   localparam logic [SW-1:0] RECIP_3 = SW'((64'd1 << SW) / 3);
   localparam logic [SW-1:0] RECIP_4 = SW'((64'd1 << SW) / 4);
   localparam logic [SW-1:0] RECIP_6 = SW'((64'd1 << SW) / 6);
   localparam logic [SW-1:0] RECIP_9 = SW'((64'd1 << SW) / 9);

   // Configuration and position counters.
   logic [CSR_W-1:0] frame_width_ff;
   logic [AW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    cfg_ext;
   logic [WW-1:0]    eff_w;
   logic [RW-1:0]    w_r;

   // Handshake and decode of the incoming word.
   logic     advance;
   logic     accept;
   logic     act;
   logic     pix_phase;
   logic     has_out;
   mode_type req_mode;
   logic [RW-1:0] orow;
   logic [WW-1:0] ocol;
   edge_type      pos;

   // Line store: upper line in the low half, middle line in the high half.
   logic [EW-1:0] line_mem [MAX_WIDTH];
   logic [EW-1:0] mem_rd_ff;
   logic [EW-1:0] fwd_data_ff;
   logic          fwd_hit_ff;
   logic [EW-1:0] line_q;
   logic [EW-1:0] wr_data;
   logic          mem_we;

   // Stage A: accepted word waiting for its line store data.
   logic          a_valid_ff;
   logic          a_out_ff;
   logic [AW-1:0] a_col_ff;
   logic [CB-1:0] a_pix_ff [3];
   edge_type      a_edge_ff;

   // Stage B: 3x3 window, indexed [column][row][channel].
   logic [CB-1:0] win_ff [3][3][3];
   logic          b_valid_ff;
   edge_type      b_edge_ff;

   // Stage C: column sums, indexed [channel][column].
   logic           c_valid_ff;
   logic [CSW-1:0] c_sum_ff [3][3];
   edge_type       c_edge_ff;

   // Stage D: full sums and divisor.
   logic          d_valid_ff;
   logic [SW-1:0] d_sum_ff [3];
   logic [3:0]    d_cnt_ff;
   logic [SW-1:0] d_recip_ff;
   logic          d_last_ff;
   logic [1:0]    n_rows;
   logic [1:0]    n_cols;
   logic [3:0]    cnt_in;
   logic [SW-1:0] recip_in;

   // Stage E: quotient estimates.
   logic            e_valid_ff;
   logic [SW-1:0]   e_quot_ff [3];
   logic [SW-1:0]   e_sum_ff [3];
   logic [3:0]      e_cnt_ff;
   logic            e_last_ff;
   logic [2*SW-1:0] prod [3];

   // Output register.
   logic          rsp_valid_ff;
   logic [CB-1:0] rsp_chan_ff [3];
   logic          rsp_last_ff;
   logic [SW-1:0] quot_fix [3];
   logic [SW-1:0] rem [3];

   // Effective frame width after clamping.
   always_comb begin
      cfg_ext = CW'(frame_width_ff);
      if (cfg_ext == '0) begin
         eff_w = WW'(1);
      end else if (cfg_ext > CW'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(cfg_ext);
      end
      w_r = RW'(eff_w);
   end

   // The whole pipeline moves when the output register can take a word.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign req_mode   = mode_type'(req_tuser[0]);

   // Decide whether the word counts and where its released output sits.
   always_comb begin
      pix_phase = row_ff < w_r;
      act = accept && ((req_mode == MODE_DRAIN) ? !pix_phase : pix_phase);
      has_out = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0));
      if (col_ff != '0) begin
         orow = row_ff - RW'(1);
         ocol = WW'(col_ff) - WW'(1);
      end else begin
         orow = row_ff - RW'(2);
         ocol = eff_w - WW'(1);
      end
      pos.top    = (orow == '0);
      pos.bottom = (orow == w_r - RW'(1));
      pos.left   = (ocol == '0);
      pos.right  = (ocol == eff_w - WW'(1));
      pos.last   = pos.bottom && pos.right;
   end

   // Next raster position; the frame restarts after the last drain word.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (row_ff == w_r + RW'(1)) begin
         col_in = '0;
         row_in = '0;
      end else if (WW'(col_ff) == eff_w - WW'(1)) begin
         col_in = '0;
         row_in = row_ff + RW'(1);
      end else begin
         col_in = col_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
      end else if (csr_we) begin
         frame_width_ff <= csr_wdata;
         col_ff         <= '0;
         row_ff         <= '0;
      end else if (act) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store write-back data: middle moves up, new pixel becomes middle.
   always_comb begin
      line_q  = fwd_hit_ff ? fwd_data_ff : mem_rd_ff;
      mem_we  = advance && a_valid_ff;
      wr_data = '0;
      for (int ch = 0; ch < 3; ch++) begin
         wr_data[ch*CB +: CB]     = line_q[(3+ch)*CB +: CB];
         wr_data[(3+ch)*CB +: CB] = a_pix_ff[ch];
      end
   end

   // Line store with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[a_col_ff] <= wr_data;
      end
      if (act) begin
         mem_rd_ff <= line_mem[col_ff];
      end
   end

   // Forward a write-back that lands on the entry being read.
   always_ff @(posedge clock) begin
      if (act) begin
         fwd_hit_ff  <= mem_we && (a_col_ff == col_ff);
         fwd_data_ff <= wr_data;
      end
   end

   // Stage A.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= act;
      end
   end

   always_ff @(posedge clock) begin
      if (act) begin
         a_out_ff  <= has_out;
         a_col_ff  <= col_ff;
         a_edge_ff <= pos;
         for (int ch = 0; ch < 3; ch++) begin
            a_pix_ff[ch] <= (req_mode == MODE_DRAIN) ? '0 : req_tdata[ch*CHAN_W +: CB];
         end
      end
   end

   // Stage B: shift the window and bring in the new column.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff && a_out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && a_valid_ff) begin
         b_edge_ff <= a_edge_ff;
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         for (int ch = 0; ch < 3; ch++) begin
            win_ff[2][0][ch] <= line_q[ch*CB +: CB];
            win_ff[2][1][ch] <= line_q[(3+ch)*CB +: CB];
            win_ff[2][2][ch] <= a_pix_ff[ch];
         end
      end
   end

   // Stage C: per-column sums, rows outside the frame left out.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_edge_ff <= b_edge_ff;
         for (int ch = 0; ch < 3; ch++) begin
            for (int cl = 0; cl < 3; cl++) begin
               c_sum_ff[ch][cl] <=
                  (b_edge_ff.top ? CSW'(0) : CSW'(win_ff[cl][0][ch])) +
                  CSW'(win_ff[cl][1][ch]) +
                  (b_edge_ff.bottom ? CSW'(0) : CSW'(win_ff[cl][2][ch]));
            end
         end
      end
   end

   // Neighbor count and its reciprocal.
   always_comb begin
      n_rows = 2'd3 - {1'b0, c_edge_ff.top} - {1'b0, c_edge_ff.bottom};
      n_cols = 2'd3 - {1'b0, c_edge_ff.left} - {1'b0, c_edge_ff.right};
      cnt_in = {2'b00, n_rows} * {2'b00, n_cols};
      unique case (cnt_in)
         4'd1:    recip_in = RECIP_1;
         4'd2:    recip_in = RECIP_2;
         4'd3:    recip_in = RECIP_3;
         4'd4:    recip_in = RECIP_4;
         4'd6:    recip_in = RECIP_6;
         4'd9:    recip_in = RECIP_9;
         default: recip_in = RECIP_1;
      endcase
   end

   // Stage D: add the columns that lie inside the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_cnt_ff   <= cnt_in;
         d_recip_ff <= recip_in;
         d_last_ff  <= c_edge_ff.last;
         for (int ch = 0; ch < 3; ch++) begin
            d_sum_ff[ch] <= (c_edge_ff.left ? SW'(0) : SW'(c_sum_ff[ch][0])) +
                            SW'(c_sum_ff[ch][1]) +
                            (c_edge_ff.right ? SW'(0) : SW'(c_sum_ff[ch][2]));
         end
      end
   end

   // Stage E: quotient estimate by reciprocal multiplication.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = {{SW{1'b0}}, d_sum_ff[ch]} * {{SW{1'b0}}, d_recip_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_cnt_ff  <= d_cnt_ff;
         e_last_ff <= d_last_ff;
         for (int ch = 0; ch < 3; ch++) begin
            e_quot_ff[ch] <= prod[ch][2*SW-1:SW];
            e_sum_ff[ch]  <= d_sum_ff[ch];
         end
      end
   end

   // The estimate is at most one low; correct it from the remainder.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         rem[ch] = e_sum_ff[ch] - (e_quot_ff[ch] * SW'(e_cnt_ff));
         quot_fix[ch] = (rem[ch] >= SW'(e_cnt_ff)) ? e_quot_ff[ch] + SW'(1) : e_quot_ff[ch];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_last_ff <= e_last_ff;
         for (int ch = 0; ch < 3; ch++) begin
            rsp_chan_ff[ch] <= quot_fix[ch][CB-1:0];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      rsp_tdata = '0;
      for (int ch = 0; ch < 3; ch++) begin
         rsp_tdata[ch*CHAN_W +: CHAN_W] = CHAN_W'(rsp_chan_ff[ch]);
      end
   end

`ifndef SYNTHESIS
   // The column counter stays inside the current frame width.
   assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < eff_w)
      else $error("column counter beyond frame width");

   // The row counter only reaches the restart row at column zero.
   assert property (@(posedge clock) disable iff (reset)
      (row_ff <= w_r + RW'(1)) && ((row_ff != w_r + RW'(1)) || (col_ff == '0)))
      else $error("row counter out of range");

   // Line store data for a waiting word holds through a stall.
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !advance) |=> ($stable(mem_rd_ff) && $stable(fwd_hit_ff)))
      else $error("line store read data lost during stall");

   // Only real neighbor counts reach the divider.
   assert property (@(posedge clock) disable iff (reset)
      d_valid_ff |-> (d_cnt_ff == 4'd1 || d_cnt_ff == 4'd2 || d_cnt_ff == 4'd3 ||
                      d_cnt_ff == 4'd4 || d_cnt_ff == 4'd6 || d_cnt_ff == 4'd9))
      else $error("bad neighbor count");
`endif

endmodule
